/* rtl/core/wes_pkg.sv */
// Package for the weighted edit-script block: edit kinds, request codes,
// register indexes, fixed widths and controller states. No dependencies.
`default_nettype none
package wes_pkg;
   localparam logic [1:0] KIND_SKIP = 2'd0;
   localparam logic [1:0] KIND_DEL  = 2'd1;
   localparam logic [1:0] KIND_INS  = 2'd2;
   localparam logic [1:0] KIND_REP  = 2'd3;

   localparam logic [1:0] FUNC_SRC = 2'd0;
   localparam logic [1:0] FUNC_DST = 2'd1;
   localparam logic [1:0] FUNC_RUN = 2'd2;
   localparam logic [1:0] FUNC_NOP = 2'd3;

   localparam logic [1:0] REG_SKIP = 2'd0;
   localparam logic [1:0] REG_DEL  = 2'd1;
   localparam logic [1:0] REG_INS  = 2'd2;
   localparam logic [1:0] REG_REP  = 2'd3;

   localparam int COST_BITS = 15;
   localparam int CHAR_BITS = 8;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROW0, ST_RDC, ST_CELL, ST_TBRD, ST_TBWAIT, ST_TBUSE,
      ST_EMRD, ST_EMWAIT, ST_EMIT
   } state_type;
endpackage
`default_nettype wire

/* rtl/core/weighted_edit_script.sv */
// Weighted edit-script engine: string buffers, cost rows, choice matrix,
// traceback path memory and the sequencer. Uses wes_pkg.
// Append items, unused codes and a run on two empty strings are handled in ST_IDLE.
// Other runs fill row zero, then per cell read (ST_RDC) and compute and write
// back (ST_CELL), or only ST_RDC per row for an empty source, then trace back
// (ST_TBRD/TBWAIT/TBUSE) and emit (ST_EMRD/EMWAIT/EMIT), held by output stalls.
// Synchronous active-high reset clears lengths, flag, output valid and the
// sequencer, loads default costs; memories are uncleared, written before use.
`default_nettype none
module weighted_edit_script #(
   parameter int MAX_LEN   = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // ch[7:0]
   input  wire  [1:0]  req_tuser,   // func[1:0]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [7:0]  csr_data,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // src_char[7:0], dst_char[15:8], truncated[16],
                                    // zero fill
   output logic [2:0]  rsp_tuser,   // kind[1:0], empty_res[2]
   output logic        rsp_tlast    // is_last
);
   localparam int CHAR_BITS = wes_pkg::CHAR_BITS;
   localparam int LW  = $clog2(MAX_LEN + 1);
   localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DIM = MAX_LEN + 1;
   localparam int MW  = $clog2(DIM * DIM);
   localparam int RW  = $clog2(2 * DIM);
   localparam int PN  = 2 * MAX_LEN;
   localparam int PW  = $clog2(PN + 1);
   localparam int PAW = $clog2(PN);
   localparam int CB  = wes_pkg::COST_BITS;

   // Configuration registers.
   logic [7:0] skip_ff, del_ff, ins_ff, rep_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 8'd1; del_ff <= 8'd10; ins_ff <= 8'd15; rep_ff <= 8'd5;
      end else if (csr_valid) begin
         unique case (csr_index)
            wes_pkg::REG_SKIP: skip_ff <= csr_data;
            wes_pkg::REG_DEL:  del_ff  <= csr_data;
            wes_pkg::REG_INS:  ins_ff  <= csr_data;
            wes_pkg::REG_REP:  rep_ff  <= csr_data;
         endcase
      end
   end

   // Memories.
   logic [CHAR_BITS-1:0] src_mem [MAX_LEN];
   logic [CHAR_BITS-1:0] dst_mem [MAX_LEN];
   logic [CB-1:0]        row_mem [2*DIM];
   logic [1:0]           ch_mem  [DIM*DIM];
   logic [2*CHAR_BITS+1:0] path_mem [PN];

   wes_pkg::state_type state_ff, state_in;
   logic [LW-1:0] slen_ff, slen_in, tlen_ff, tlen_in;
   logic          drop_ff, drop_in;
   logic [LW-1:0] f_ff, f_in, t_ff, t_in;
   logic [CB-1:0] left_ff, left_in;     // cur[f-1]
   logic [CB-1:0] acc_ff, acc_in;       // running f*delete, then t*insert for column zero
   logic [PW-1:0] n_ff, n_in, k_ff, k_in;
   logic          ovalid_ff, ovalid_in;
   logic [1:0]    okind_ff, okind_in;
   logic [7:0]    osrc_ff, osrc_in, odst_ff, odst_in;
   logic          olast_ff, olast_in, oempty_ff, oempty_in, otrunc_ff, otrunc_in;

   // Memory read data registers.
   logic [CHAR_BITS-1:0] srd_ff, trd_ff;
   logic [CB-1:0]        pdiag_ff, pup_ff;
   logic [1:0]           crd_ff;
   logic [2*CHAR_BITS+1:0] prd_ff;

   logic [AW-1:0] s_ra, t_ra;
   logic [RW-1:0] r_ra0, r_ra1, r_wa;
   logic [MW-1:0] c_ra, c_wa;
   logic [PAW-1:0] p_ra;
   logic          r_we, c_we, p_we;
   logic [CB-1:0] r_wd;
   logic [1:0]    c_wd;
   logic [PAW-1:0] p_wa;
   logic [2*CHAR_BITS+1:0] p_wd;
   logic          s_we, t_we;

   logic [1:0]           func;
   logic [CHAR_BITS-1:0] chv;
   assign func = req_tuser;
   assign chv  = req_tdata[CHAR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (s_we) src_mem[slen_ff[AW-1:0]] <= chv;
      if (t_we) dst_mem[tlen_ff[AW-1:0]] <= chv;
      if (r_we) row_mem[r_wa] <= r_wd;
      if (c_we) ch_mem[c_wa] <= c_wd;
      if (p_we) path_mem[p_wa] <= p_wd;
      srd_ff   <= src_mem[s_ra];
      trd_ff   <= dst_mem[t_ra];
      pdiag_ff <= row_mem[r_ra0];
      pup_ff   <= row_mem[r_ra1];
      crd_ff   <= ch_mem[c_ra];
      prd_ff   <= path_mem[p_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wes_pkg::ST_IDLE; slen_ff <= '0; tlen_ff <= '0;
         drop_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; slen_ff <= slen_in; tlen_ff <= tlen_in;
         drop_ff <= drop_in; ovalid_ff <= ovalid_in;
      end
      f_ff <= f_in; t_ff <= t_in; left_ff <= left_in; acc_ff <= acc_in;
      n_ff <= n_in; k_ff <= k_in; okind_ff <= okind_in; osrc_ff <= osrc_in;
      odst_ff <= odst_in; olast_ff <= olast_in; oempty_ff <= oempty_in;
      otrunc_ff <= otrunc_in;
   end

   // Cell computation helpers.
   logic          same;
   logic [CB-1:0] ic, dc, rc;
   logic [1:0]    ckind;
   logic [CB-1:0] cval;
   logic          tpar;
   logic          out_free;
   assign out_free = !ovalid_ff || rsp_tready;

   function automatic logic [RW-1:0] raddr(input logic p, input logic [LW-1:0] i);
      raddr = p ? RW'(DIM + 32'(i)) : RW'(i);
   endfunction

   function automatic logic [MW-1:0] caddr(input logic [LW-1:0] tt, input logic [LW-1:0] ff);
      caddr = MW'(32'(tt) * DIM + 32'(ff));
   endfunction

   always_comb begin
      state_in = state_ff; slen_in = slen_ff; tlen_in = tlen_ff; drop_in = drop_ff;
      f_in = f_ff; t_in = t_ff; left_in = left_ff; acc_in = acc_ff;
      n_in = n_ff; k_in = k_ff; ovalid_in = ovalid_ff && !rsp_tready;
      okind_in = okind_ff; osrc_in = osrc_ff; odst_in = odst_ff; olast_in = olast_ff;
      oempty_in = oempty_ff; otrunc_in = otrunc_ff;
      req_tready = 1'b0; s_we = 1'b0; t_we = 1'b0; r_we = 1'b0; c_we = 1'b0;
      p_we = 1'b0; r_wa = '0; r_wd = '0; c_wa = '0; c_wd = '0; p_wa = '0; p_wd = '0;
      s_ra = '0; t_ra = '0; r_ra0 = '0; r_ra1 = '0; c_ra = '0; p_ra = '0;
      tpar = t_ff[0];
      same = srd_ff == trd_ff;
      ic = pup_ff + CB'(ins_ff);
      dc = left_ff + CB'(del_ff);
      rc = pdiag_ff + CB'(same ? skip_ff : rep_ff);
      if (ic < dc && ic < rc) begin
         cval = ic; ckind = wes_pkg::KIND_INS;
      end else if (dc < rc) begin
         cval = dc; ckind = wes_pkg::KIND_DEL;
      end else begin
         cval = rc; ckind = same ? wes_pkg::KIND_SKIP : wes_pkg::KIND_REP;
      end
      unique case (state_ff)
         wes_pkg::ST_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && req_tready) begin
               unique case (func)
                  wes_pkg::FUNC_SRC: begin
                     if (32'(slen_ff) < MAX_LEN) begin
                        s_we = 1'b1; slen_in = slen_ff + 1'b1;
                     end else drop_in = 1'b1;
                  end
                  wes_pkg::FUNC_DST: begin
                     if (32'(tlen_ff) < MAX_LEN) begin
                        t_we = 1'b1; tlen_in = tlen_ff + 1'b1;
                     end else drop_in = 1'b1;
                  end
                  wes_pkg::FUNC_RUN: begin
                     if (slen_ff == '0 && tlen_ff == '0) begin
                        ovalid_in = 1'b1; okind_in = wes_pkg::KIND_SKIP;
                        osrc_in = '0; odst_in = '0; olast_in = 1'b1;
                        oempty_in = 1'b1; otrunc_in = drop_ff; drop_in = 1'b0;
                     end else begin
                        f_in = '0; acc_in = '0; state_in = wes_pkg::ST_ROW0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // Row zero: f * delete cost, delete choices.
         wes_pkg::ST_ROW0: begin
            r_we = 1'b1; r_wa = raddr(1'b0, f_ff); r_wd = acc_ff;
            c_we = 1'b1; c_wa = caddr('0, f_ff); c_wd = wes_pkg::KIND_DEL;
            acc_in = acc_ff + CB'(del_ff);
            if (f_ff == slen_ff) begin
               t_in = LW'(1); acc_in = CB'(ins_ff);
               if (tlen_ff == '0) begin
                  f_in = slen_ff; t_in = '0; n_in = '0; state_in = wes_pkg::ST_TBRD;
               end else state_in = wes_pkg::ST_RDC;
            end else f_in = f_ff + 1'b1;
            if (f_ff == slen_ff && tlen_ff != '0) begin
               // Column zero of row one starts next.
               f_in = '0;
            end
         end
         // Issue reads for cell (t, f+1); column zero written here.
         wes_pkg::ST_RDC: begin
            if (f_ff == '0) begin
               r_we = 1'b1; r_wa = raddr(tpar, '0); r_wd = acc_ff;
               c_we = 1'b1; c_wa = caddr(t_ff, '0); c_wd = wes_pkg::KIND_INS;
               left_in = acc_ff;
            end
            s_ra = f_ff[AW-1:0]; t_ra = AW'(t_ff - 1'b1);
            r_ra0 = raddr(!tpar, f_ff); r_ra1 = raddr(!tpar, f_ff + 1'b1);
            if (slen_ff == '0) begin
               // An empty source leaves only column zero in each row.
               acc_in = acc_ff + CB'(ins_ff);
               if (t_ff == tlen_ff) begin
                  n_in = '0; state_in = wes_pkg::ST_TBRD;
               end else t_in = t_ff + 1'b1;
            end else state_in = wes_pkg::ST_CELL;
         end
         wes_pkg::ST_CELL: begin
            r_we = 1'b1; r_wa = raddr(tpar, f_ff + 1'b1); r_wd = cval;
            c_we = 1'b1; c_wa = caddr(t_ff, f_ff + 1'b1); c_wd = ckind;
            left_in = cval;
            state_in = wes_pkg::ST_RDC;
            if (f_ff + 1'b1 == slen_ff) begin
               f_in = '0;
               acc_in = acc_ff + CB'(ins_ff);
               if (t_ff == tlen_ff) begin
                  f_in = slen_ff; n_in = '0; state_in = wes_pkg::ST_TBRD;
               end else t_in = t_ff + 1'b1;
            end else f_in = f_ff + 1'b1;
         end
         // Traceback: read choice and characters, record path entry.
         wes_pkg::ST_TBRD: begin
            if ((f_ff == '0 && t_ff == '0) || 32'(n_ff) >= PN) begin
               k_in = n_ff; state_in = wes_pkg::ST_EMRD;
            end else begin
               c_ra = caddr(t_ff, f_ff);
               s_ra = AW'(f_ff - 1'b1); t_ra = AW'(t_ff - 1'b1);
               state_in = wes_pkg::ST_TBWAIT;
            end
         end
         // The read addresses stay put so the data registers keep the entry.
         wes_pkg::ST_TBWAIT: begin
            c_ra = caddr(t_ff, f_ff);
            s_ra = AW'(f_ff - 1'b1); t_ra = AW'(t_ff - 1'b1);
            state_in = wes_pkg::ST_TBUSE;
         end
         wes_pkg::ST_TBUSE: begin
            p_we = 1'b1; p_wa = PAW'(n_ff);
            p_wd = {crd_ff,
                    (crd_ff != wes_pkg::KIND_INS && f_ff != '0) ? srd_ff : CHAR_BITS'(0),
                    (crd_ff != wes_pkg::KIND_DEL && t_ff != '0) ? trd_ff : CHAR_BITS'(0)};
            if (crd_ff != wes_pkg::KIND_INS && f_ff != '0) f_in = f_ff - 1'b1;
            if (crd_ff != wes_pkg::KIND_DEL && t_ff != '0) t_in = t_ff - 1'b1;
            n_in = n_ff + 1'b1;
            state_in = wes_pkg::ST_TBRD;
         end
         // Emit path back to front: k counts down.
         wes_pkg::ST_EMRD: begin
            p_ra = PAW'(k_ff - 1'b1);
            state_in = wes_pkg::ST_EMWAIT;
         end
         wes_pkg::ST_EMWAIT: begin
            p_ra = PAW'(k_ff - 1'b1);
            state_in = wes_pkg::ST_EMIT;
         end
         wes_pkg::ST_EMIT: begin
            p_ra = PAW'(k_ff - 1'b1);
            if (out_free) begin
               ovalid_in = 1'b1;
               okind_in = prd_ff[2*CHAR_BITS +: 2];
               osrc_in = 8'(prd_ff[CHAR_BITS +: CHAR_BITS]);
               odst_in = 8'(prd_ff[0 +: CHAR_BITS]);
               olast_in = k_ff == PW'(1); oempty_in = 1'b0; otrunc_in = drop_ff;
               k_in = k_ff - 1'b1;
               if (k_ff == PW'(1)) begin
                  slen_in = '0; tlen_in = '0; drop_in = 1'b0;
                  state_in = wes_pkg::ST_IDLE;
               end else state_in = wes_pkg::ST_EMRD;
            end
         end
         default: state_in = wes_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {7'd0, otrunc_ff, odst_ff, osrc_ff};
   assign rsp_tuser  = {oempty_ff, okind_ff};
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for the weighted edit-script block: directed and random string
// pairs, cost register changes, and a scoreboard that predicts each script.
// Depends on wes_pkg and weighted_edit_script.
`default_nettype none
module tb_top;
   localparam int MAXL = 32;
   localparam int WATCHDOG_LIMIT = 200000;

   // Expected script item.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] src_char;
      logic [7:0] dst_char;
      logic       is_last;
      logic       empty_res;
      logic       truncated;
   } edit_item_type;

   // Scoreboard: mirrors the block state and holds the expected script items.
   class edit_scoreboard;
      logic [7:0] cost_reg [4];
      logic [7:0] src_str [MAXL];
      logic [7:0] dst_str [MAXL];
      int unsigned src_n, dst_n;
      bit dropped;
      edit_item_type pending [$];
      int errors;

      function void clear();
         cost_reg[0] = 8'd1; cost_reg[1] = 8'd10;
         cost_reg[2] = 8'd15; cost_reg[3] = 8'd5;
         src_n = 0; dst_n = 0; dropped = 0; errors = 0;
         pending.delete();
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] val);
         cost_reg[idx] = val;
      endfunction

      // Builds the cost matrix, traces back and queues the script.
      function void solve_script();
         int unsigned cost [0:MAXL][0:MAXL];
         logic [1:0] pick [0:MAXL][0:MAXL];
         edit_item_type path [$];
         edit_item_type it;
         int unsigned ic, dc, rc, f, t;
         bit same;
         if (src_n == 0 && dst_n == 0) begin
            it = '{wes_pkg::KIND_SKIP, 8'd0, 8'd0, 1'b1, 1'b1, dropped};
            pending.push_back(it);
            return;
         end
         cost[0][0] = 0;
         for (f = 1; f <= src_n; f++) begin
            cost[0][f] = f * cost_reg[wes_pkg::REG_DEL];
            pick[0][f] = wes_pkg::KIND_DEL;
         end
         for (t = 1; t <= dst_n; t++) begin
            cost[t][0] = t * cost_reg[wes_pkg::REG_INS];
            pick[t][0] = wes_pkg::KIND_INS;
            for (f = 1; f <= src_n; f++) begin
               same = src_str[f-1] == dst_str[t-1];
               ic = cost[t-1][f] + cost_reg[wes_pkg::REG_INS];
               dc = cost[t][f-1] + cost_reg[wes_pkg::REG_DEL];
               rc = cost[t-1][f-1] + (same ? cost_reg[wes_pkg::REG_SKIP] :
                                             cost_reg[wes_pkg::REG_REP]);
               if (ic < dc && ic < rc) begin
                  cost[t][f] = ic & 16'h7fff; pick[t][f] = wes_pkg::KIND_INS;
               end else if (dc < rc) begin
                  cost[t][f] = dc & 16'h7fff; pick[t][f] = wes_pkg::KIND_DEL;
               end else begin
                  cost[t][f] = rc & 16'h7fff;
                  pick[t][f] = same ? wes_pkg::KIND_SKIP : wes_pkg::KIND_REP;
               end
            end
         end
         // The path is collected from the end back to the start.
         f = src_n; t = dst_n;
         while ((f > 0 || t > 0) && path.size() < 2 * MAXL) begin
            it = '0;
            it.kind = pick[t][f];
            it.truncated = dropped;
            if (it.kind != wes_pkg::KIND_INS && f > 0) it.src_char = src_str[f-1];
            if (it.kind != wes_pkg::KIND_DEL && t > 0) it.dst_char = dst_str[t-1];
            path.push_back(it);
            if (it.kind != wes_pkg::KIND_INS && f > 0) f--;
            if (it.kind != wes_pkg::KIND_DEL && t > 0) t--;
         end
         path[0].is_last = 1'b1;
         for (int i = path.size() - 1; i >= 0; i--) pending.push_back(path[i]);
      endfunction

      // Notes an accepted request.
      function void note_request(logic [1:0] func, logic [7:0] ch);
         case (func)
            wes_pkg::FUNC_SRC: begin
               if (src_n < MAXL) src_str[src_n++] = ch; else dropped = 1;
            end
            wes_pkg::FUNC_DST: begin
               if (dst_n < MAXL) dst_str[dst_n++] = ch; else dropped = 1;
            end
            wes_pkg::FUNC_RUN: begin
               solve_script();
               src_n = 0; dst_n = 0; dropped = 0;
            end
            default: ;
         endcase
      endfunction

      // Checks an accepted result against the oldest expectation.
      function void check_result(logic [2:0] user, logic [23:0] data, logic last);
         edit_item_type e;
         if (pending.size() == 0) begin
            $error("unexpected result tuser=%h tdata=%h tlast=%b", user, data, last);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (user[1:0] != e.kind) begin
            $error("kind expected %0d actual %0d", e.kind, user[1:0]); errors++;
         end
         if (data[7:0] != e.src_char) begin
            $error("src_char expected %h actual %h", e.src_char, data[7:0]); errors++;
         end
         if (data[15:8] != e.dst_char) begin
            $error("dst_char expected %h actual %h", e.dst_char, data[15:8]); errors++;
         end
         if (last != e.is_last) begin
            $error("is_last expected %b actual %b", e.is_last, last); errors++;
         end
         if (user[2] != e.empty_res) begin
            $error("empty_res expected %b actual %b", e.empty_res, user[2]); errors++;
         end
         if (data[16] != e.truncated) begin
            $error("truncated expected %b actual %b", e.truncated, data[16]); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tlast;

   edit_scoreboard board = new();
   int idle_cycles = 0;
   bit fast_phase;

   always #5 clock = ~clock;

   weighted_edit_script u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // Sample transactions at the rising edge; watchdog counts quiet cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // Result side: random stall before each accepted result, none in the fast phase.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = fast_phase ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_request(input logic [1:0] func, input logic [7:0] ch);
      int gap;
      gap = fast_phase ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= ch;
      req_tuser <= func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic end_request();
      req_tvalid <= 0;
   endtask

   task automatic write_cost(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic end_cost();
      csr_valid <= 0;
   endtask

   // Waits until every expected result arrived, then a settling pause.
   task automatic drain();
      end_request();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic send_pair(input int ns, input int nd, input int alpha);
      for (int i = 0; i < ns; i++)
         send_request(wes_pkg::FUNC_SRC, 8'($urandom_range(0, alpha)));
      for (int i = 0; i < nd; i++)
         send_request(wes_pkg::FUNC_DST, 8'($urandom_range(0, alpha)));
      send_request(wes_pkg::FUNC_RUN, 8'($urandom));
   endtask

   task automatic random_costs();
      for (int r = 0; r < 4; r++) begin
         case ($urandom_range(0, 3))
            0: write_cost(2'(r), 8'd0);
            1: write_cost(2'(r), 8'd255);
            default: write_cost(2'(r), 8'($urandom));
         endcase
      end
   endtask

   // Main stimulus.
   initial begin
      board.clear();
      fast_phase = 0;
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: empty run, extreme characters, unused code, one-sided runs.
      send_request(wes_pkg::FUNC_RUN, 8'hff);
      send_request(wes_pkg::FUNC_SRC, 8'h00);
      send_request(wes_pkg::FUNC_SRC, 8'hff);
      send_request(wes_pkg::FUNC_DST, 8'hff);
      send_request(wes_pkg::FUNC_NOP, 8'h55);
      send_request(wes_pkg::FUNC_DST, 8'h00);
      send_request(wes_pkg::FUNC_RUN, 8'h00);
      send_request(wes_pkg::FUNC_SRC, 8'h41);
      send_request(wes_pkg::FUNC_RUN, 8'h00);
      send_request(wes_pkg::FUNC_DST, 8'h42);
      send_request(wes_pkg::FUNC_RUN, 8'h00);
      drain();
      // Overflow both buffers, then a destination-only run after truncation.
      for (int i = 0; i < 33; i++) send_request(wes_pkg::FUNC_SRC, 8'(i * 7));
      for (int i = 0; i < 33; i++) send_request(wes_pkg::FUNC_DST, 8'(i * 5));
      send_request(wes_pkg::FUNC_RUN, 8'h00);
      for (int i = 0; i < 33; i++) send_request(wes_pkg::FUNC_DST, 8'hAA);
      send_request(wes_pkg::FUNC_RUN, 8'h00);
      drain();

      // Random phases with changing costs, extremes included.
      for (int phase = 0; phase < 8; phase++) begin
         fast_phase = (phase == 3);
         case (phase)
            0: for (int r = 0; r < 4; r++) write_cost(2'(r), 8'd0);
            1: for (int r = 0; r < 4; r++) write_cost(2'(r), 8'd255);
            default: random_costs();
         endcase
         end_cost();
         for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(wes_pkg::FUNC_NOP, 8'($urandom));
               send_pair(0, 0, 255);
            end else begin
               int ns, nd;
               ns = ($urandom_range(0, 15) == 0) ? 32 : $urandom_range(0, 5);
               nd = ($urandom_range(0, 15) == 0) ? 32 : $urandom_range(0, 5);
               send_pair(ns, nd, ($urandom_range(0, 1) != 0) ? 3 : 255);
            end
         end
         drain();
      end
      fast_phase = 0;

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

/* weighted_edit_script.f */
rtl/core/wes_pkg.sv
rtl/core/weighted_edit_script.sv
tb/sv/tb_top.sv
